>>> sv/quaternion_to_rotation_matrix_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion to rotation matrix unit
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

// same-cycle implication
`define Q2RM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("q2rm assertion failed");

// next-cycle implication
`define Q2RM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("q2rm assertion failed");

`endif

>>> sv/q2rm_pkg.sv
// ----------------------------------------------------------------------------
// q2rm_pkg
// Widths, types and helpers of the quaternion to rotation matrix unit.
// ----------------------------------------------------------------------------
package q2rm_pkg;

    localparam int unsigned COMPONENT_WIDTH = 16;
    localparam int unsigned FRACTION_BITS   = 14;
    localparam int unsigned CW     = COMPONENT_WIDTH;
    localparam int unsigned FB     = FRACTION_BITS;
    localparam int unsigned PW     = 2 * CW;
    localparam int unsigned QW     = 2 * CW + 1;
    localparam int unsigned NW     = QW + 1;
    localparam int unsigned RW     = FB + 1;
    localparam int unsigned TW     = 15;
    localparam int unsigned NLANE  = 9;
    localparam int unsigned LIM    = 1 << FB;
    localparam int unsigned WMAX   = (1 << (CW - 1)) - 1;
    localparam int unsigned ONE    = (LIM > WMAX) ? WMAX : LIM;
    localparam logic [TW-1:0] THRESH_RESET = TW'(16);

    typedef logic signed [CW-1:0] t_comp;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [NW-1:0] t_num;

    typedef struct packed {
        logic [QW-1:0]             q;
        logic [NLANE-1:0][QW-1:0]  r;
        logic [NLANE-1:0][FB-1:0]  res;
        logic [NLANE-1:0]          sat;
        logic [NLANE-1:0]          neg;
        logic                      zero;
    } t_div;

    typedef struct packed {
        logic [NLANE-1:0][CW-1:0]  m;
        logic                      zero;
    } t_mat;

    function automatic t_num sext(input t_prod v);
        return NW'(v);
    endfunction

endpackage

>>> sv/q2rm_if.sv
// ----------------------------------------------------------------------------
// q2rm channel interfaces
// Quaternion input, matrix output and threshold write channels.
// ----------------------------------------------------------------------------
interface q2rm_in_if;
    logic                 valid;
    logic                 ready;
    q2rm_pkg::t_comp      q_scalar;
    q2rm_pkg::t_comp      q_x;
    q2rm_pkg::t_comp      q_y;
    q2rm_pkg::t_comp      q_z;
    modport source (output valid, q_scalar, q_x, q_y, q_z, input ready);
    modport sink   (input valid, q_scalar, q_x, q_y, q_z, output ready);
endinterface

interface q2rm_out_if;
    logic                 valid;
    logic                 ready;
    q2rm_pkg::t_comp      col0_row0;
    q2rm_pkg::t_comp      col0_row1;
    q2rm_pkg::t_comp      col0_row2;
    q2rm_pkg::t_comp      col1_row0;
    q2rm_pkg::t_comp      col1_row1;
    q2rm_pkg::t_comp      col1_row2;
    q2rm_pkg::t_comp      col2_row0;
    q2rm_pkg::t_comp      col2_row1;
    q2rm_pkg::t_comp      col2_row2;
    logic                 zero_quaternion;
    modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                    col1_row2, col2_row0, col2_row1, col2_row2, zero_quaternion,
                    input ready);
    modport sink   (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                    col1_row2, col2_row0, col2_row1, col2_row2, zero_quaternion,
                    output ready);
endinterface

interface q2rm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [q2rm_pkg::TW-1:0]       clean_threshold;
    modport source (output valid, clean_threshold, input ready);
    modport sink   (input valid, clean_threshold, output ready);
endinterface

>>> sv/q2rm_front.sv
// ----------------------------------------------------------------------------
// q2rm_front
// Three stages: pairwise products, quadrance and numerators, magnitudes.
// ----------------------------------------------------------------------------
module q2rm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  q2rm_pkg::t_comp      i_t,
    input  q2rm_pkg::t_comp      i_x,
    input  q2rm_pkg::t_comp      i_y,
    input  q2rm_pkg::t_comp      i_z,
    output logic                 o_valid,
    output q2rm_pkg::t_div       o_div
);
    logic [2:0] r_v;
    q2rm_pkg::t_prod r_tt, r_xx, r_yy, r_zz, r_xy, r_xz, r_xt, r_yz, r_yt, r_zt;
    logic [q2rm_pkg::QW-1:0] r_q, n_q;
    q2rm_pkg::t_num r_num [q2rm_pkg::NLANE];
    q2rm_pkg::t_num n_num [q2rm_pkg::NLANE];
    q2rm_pkg::t_div r_div, n_div;

    always_comb begin
        n_q = q2rm_pkg::QW'(unsigned'(r_tt)) + q2rm_pkg::QW'(unsigned'(r_xx))
            + q2rm_pkg::QW'(unsigned'(r_yy)) + q2rm_pkg::QW'(unsigned'(r_zz));
        n_num[0] = q2rm_pkg::sext(r_tt) + q2rm_pkg::sext(r_xx)
                 - q2rm_pkg::sext(r_yy) - q2rm_pkg::sext(r_zz);
        n_num[1] = (q2rm_pkg::sext(r_xy) + q2rm_pkg::sext(r_zt)) <<< 1;
        n_num[2] = (q2rm_pkg::sext(r_xz) - q2rm_pkg::sext(r_yt)) <<< 1;
        n_num[3] = (q2rm_pkg::sext(r_xy) - q2rm_pkg::sext(r_zt)) <<< 1;
        n_num[4] = q2rm_pkg::sext(r_tt) - q2rm_pkg::sext(r_xx)
                 + q2rm_pkg::sext(r_yy) - q2rm_pkg::sext(r_zz);
        n_num[5] = (q2rm_pkg::sext(r_yz) + q2rm_pkg::sext(r_xt)) <<< 1;
        n_num[6] = (q2rm_pkg::sext(r_xz) + q2rm_pkg::sext(r_yt)) <<< 1;
        n_num[7] = (q2rm_pkg::sext(r_yz) - q2rm_pkg::sext(r_xt)) <<< 1;
        n_num[8] = q2rm_pkg::sext(r_tt) - q2rm_pkg::sext(r_xx)
                 - q2rm_pkg::sext(r_yy) + q2rm_pkg::sext(r_zz);
    end

    always_comb begin
        q2rm_pkg::t_num a;
        n_div      = '0;
        n_div.q    = r_q;
        n_div.zero = (r_q == '0);
        for (int i = 0; i < q2rm_pkg::NLANE; i++) begin
            a = r_num[i][q2rm_pkg::NW-1] ? -r_num[i] : r_num[i];
            n_div.neg[i] = r_num[i][q2rm_pkg::NW-1];
            n_div.r[i]   = a[q2rm_pkg::QW-1:0];
            n_div.sat[i] = (a[q2rm_pkg::QW-1:0] >= r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
        if (i_en) begin
            r_tt <= i_t * i_t;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_xz <= i_x * i_z;
            r_xt <= i_x * i_t;
            r_yz <= i_y * i_z;
            r_yt <= i_y * i_t;
            r_zt <= i_z * i_t;
            r_q   <= n_q;
            r_num <= n_num;
            r_div <= n_div;
        end
    end

    assign o_valid = r_v[2];
    assign o_div   = r_div;
endmodule

>>> sv/q2rm_divider.sv
// ----------------------------------------------------------------------------
// q2rm_divider
// Restoring division pipeline, one quotient bit per stage, nine lanes.
// ----------------------------------------------------------------------------
module q2rm_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  q2rm_pkg::t_div       i_div,
    output logic                 o_valid,
    output q2rm_pkg::t_div       o_div
);
    q2rm_pkg::t_div w_st [q2rm_pkg::FB+1];
    q2rm_pkg::t_div r_st [q2rm_pkg::FB];
    logic [q2rm_pkg::FB-1:0] r_v;

    assign w_st[0] = i_div;

    for (genvar s = 0; s < q2rm_pkg::FB; s++) begin : g_stage
        q2rm_pkg::t_div n_st;
        always_comb begin
            logic [q2rm_pkg::QW:0] r2;
            n_st = w_st[s];
            for (int i = 0; i < q2rm_pkg::NLANE; i++) begin
                r2 = {w_st[s].r[i], 1'b0};
                if (r2 >= {1'b0, w_st[s].q}) begin
                    n_st.r[i]   = q2rm_pkg::QW'(r2 - {1'b0, w_st[s].q});
                    n_st.res[i] = {w_st[s].res[i][q2rm_pkg::FB-2:0], 1'b1};
                end else begin
                    n_st.r[i]   = r2[q2rm_pkg::QW-1:0];
                    n_st.res[i] = {w_st[s].res[i][q2rm_pkg::FB-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
        assign w_st[s+1] = r_st[s];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[q2rm_pkg::FB-2:0], i_valid};
        end
    end

    assign o_valid = r_v[q2rm_pkg::FB-1];
    assign o_div   = w_st[q2rm_pkg::FB];
endmodule

>>> sv/q2rm_finish.sv
// ----------------------------------------------------------------------------
// q2rm_finish
// Rounding, saturation, small-entry cleaning, sign and identity select.
// ----------------------------------------------------------------------------
module q2rm_finish (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  q2rm_pkg::t_div             i_div,
    input  logic [q2rm_pkg::TW-1:0]    i_thresh,
    output logic                       o_valid,
    output q2rm_pkg::t_mat             o_mat
);
    logic r_v;
    q2rm_pkg::t_mat r_mat, n_mat;

    always_comb begin
        logic [q2rm_pkg::RW-1:0] rnd;
        logic [q2rm_pkg::QW:0]   r2;
        n_mat.zero = i_div.zero;
        for (int i = 0; i < q2rm_pkg::NLANE; i++) begin
            r2  = {i_div.r[i], 1'b0};
            rnd = {1'b0, i_div.res[i]} + q2rm_pkg::RW'(r2 >= {1'b0, i_div.q});
            if (i_div.sat[i] || 32'(rnd) > q2rm_pkg::LIM) begin
                rnd = q2rm_pkg::RW'(q2rm_pkg::LIM);
            end
            if (32'(rnd) > q2rm_pkg::WMAX) begin
                rnd = q2rm_pkg::RW'(q2rm_pkg::WMAX);
            end
            if (32'(rnd) < 32'(i_thresh)) begin
                rnd = '0;
            end
            n_mat.m[i] = i_div.neg[i] ? -q2rm_pkg::CW'(rnd) : q2rm_pkg::CW'(rnd);
            if (i_div.zero) begin
                n_mat.m[i] = (i == 0 || i == 4 || i == 8)
                           ? q2rm_pkg::CW'(q2rm_pkg::ONE) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_mat <= n_mat;
        end
    end

    assign o_valid = r_v;
    assign o_mat   = r_mat;
endmodule

>>> sv/quaternion_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Quaternion (Q2.14) to normalized 3x3 rotation matrix (Q2.14), pipelined.
// ----------------------------------------------------------------------------
// Takes one quaternion per cycle unless the output stalls; its matrix passes 3
// front stages (products, sums, magnitudes), 14 divider stages (one quotient
// bit each) and one rounding/output stage. The whole pipeline advances while
// the output register is empty or taken; an output stall holds every stage.
module quaternion_to_rotation_matrix_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    q2rm_in_if.sink    i_in,
    q2rm_out_if.source o_out,
    q2rm_cfg_if.sink   i_cfg
);
    logic                      w_en;
    logic                      w_front_v, w_div_v, w_fin_v;
    q2rm_pkg::t_div            w_front, w_div;
    q2rm_pkg::t_mat            w_mat;
    logic [q2rm_pkg::TW-1:0]   r_thresh;

    assign w_en        = !w_fin_v || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= q2rm_pkg::THRESH_RESET;
        end else if (i_cfg.valid) begin
            r_thresh <= i_cfg.clean_threshold;
        end
    end

    q2rm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_in.valid),
        .i_t(i_in.q_scalar), .i_x(i_in.q_x), .i_y(i_in.q_y), .i_z(i_in.q_z),
        .o_valid(w_front_v), .o_div(w_front)
    );

    q2rm_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_front_v),
        .i_div(w_front), .o_valid(w_div_v), .o_div(w_div)
    );

    q2rm_finish u_fin (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_div_v),
        .i_div(w_div), .i_thresh(r_thresh), .o_valid(w_fin_v), .o_mat(w_mat)
    );

    assign o_out.valid           = w_fin_v;
    assign o_out.col0_row0       = w_mat.m[0];
    assign o_out.col0_row1       = w_mat.m[1];
    assign o_out.col0_row2       = w_mat.m[2];
    assign o_out.col1_row0       = w_mat.m[3];
    assign o_out.col1_row1       = w_mat.m[4];
    assign o_out.col1_row2       = w_mat.m[5];
    assign o_out.col2_row0       = w_mat.m[6];
    assign o_out.col2_row1       = w_mat.m[7];
    assign o_out.col2_row2       = w_mat.m[8];
    assign o_out.zero_quaternion = w_mat.zero;
endmodule

>>> sv/q2rm_checker.sv
// ----------------------------------------------------------------------------
// q2rm_checker
// Port-level checks of the quaternion to rotation matrix unit.
// ----------------------------------------------------------------------------
`include "quaternion_to_rotation_matrix_unit_assert.svh"

module q2rm_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_ready,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  q2rm_pkg::t_comp  i_c00,
    input  q2rm_pkg::t_comp  i_c01,
    input  q2rm_pkg::t_comp  i_c11,
    input  q2rm_pkg::t_comp  i_c22,
    input  logic             i_zero
);
    `Q2RM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_c00) && $stable(i_c11) && $stable(i_zero))
    `Q2RM_ASSERT_IMPL(a_zero_identity, i_out_valid && i_zero,
        i_c00 == 16'sd16384 && i_c11 == 16'sd16384 && i_c22 == 16'sd16384 && i_c01 == 16'sd0)
    `Q2RM_ASSERT_IMPL(a_range, i_out_valid,
        i_c00 <= 16'sd16384 && i_c00 >= -16'sd16384 && i_c01 <= 16'sd16384 && i_c01 >= -16'sd16384)
    `Q2RM_ASSERT_IMPL(a_ready_free, !i_out_valid || i_out_ready, i_in_ready)
endmodule

bind quaternion_to_rotation_matrix_unit q2rm_checker u_q2rm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_c00(o_out.col0_row0), .i_c01(o_out.col0_row1), .i_c11(o_out.col1_row1),
    .i_c22(o_out.col2_row2), .i_zero(o_out.zero_quaternion)
);

>>> bench/q2rm_tb_if.sv
// ----------------------------------------------------------------------------
// q2rm testbench channel notes
// The channel interfaces come with the RTL (sv/q2rm_if.sv); this file only
// holds the shared item and matrix types used by the bench.
// ----------------------------------------------------------------------------
package q2rm_tb_pkg;
    import q2rm_pkg::*;

    typedef struct packed {
        t_comp t;
        t_comp x;
        t_comp y;
        t_comp z;
    } t_quat;

    typedef struct packed {
        t_comp [8:0] m;
        logic        zero;
    } t_rot;
endpackage

>>> bench/q2rm_checker.sv
// ----------------------------------------------------------------------------
// q2rm_tb_checker
// Watches the threshold, quaternion and matrix channels, predicts each matrix
// and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module q2rm_tb_checker
    import q2rm_pkg::*;
    import q2rm_tb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    q2rm_in_if      i_in,
    q2rm_out_if     i_out,
    q2rm_cfg_if     i_cfg,
    output int      o_errors,
    output int      o_pending,
    output int      o_matrices,
    output int      o_zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [TW-1:0] threshold;
    t_rot          expected_mats[$];

    function automatic logic signed [15:0] scaled_entry(longint num, longint unsigned qd,
                                                        logic [TW-1:0] thr);
        longint unsigned mag;
        longint unsigned res;
        longint unsigned r;
        mag = num < 0 ? longint'(-num) : longint'(num);
        res = 0;
        if (mag >= qd) begin
            res = LIM;
        end else begin
            r = mag;
            for (int i = 0; i < FB; i++) begin
                r = r << 1;
                res = res << 1;
                if (r >= qd) begin
                    r = r - qd;
                    res = res | 1;
                end
            end
            r = r << 1;
            if (r >= qd) res = res + 1;
        end
        if (res > LIM) res = LIM;
        if (res > WMAX) res = WMAX;
        if (res < thr) res = 0;
        return num < 0 ? -16'(res) : 16'(res);
    endfunction

    function automatic t_rot rotation_of(t_quat qi, logic [TW-1:0] thr);
        longint t, x, y, z, qd;
        t_rot   r;
        t = qi.t; x = qi.x; y = qi.y; z = qi.z;
        qd = t*t + x*x + y*y + z*z;
        r.zero = (qd == 0);
        if (qd == 0) begin
            r.m = '0;
            r.m[0] = t_comp'(ONE);
            r.m[4] = t_comp'(ONE);
            r.m[8] = t_comp'(ONE);
        end else begin
            r.m[0] = scaled_entry(t*t + x*x - y*y - z*z, qd, thr);
            r.m[1] = scaled_entry(2*(x*y + z*t), qd, thr);
            r.m[2] = scaled_entry(2*(x*z - y*t), qd, thr);
            r.m[3] = scaled_entry(2*(x*y - z*t), qd, thr);
            r.m[4] = scaled_entry(t*t - x*x + y*y - z*z, qd, thr);
            r.m[5] = scaled_entry(2*(y*z + x*t), qd, thr);
            r.m[6] = scaled_entry(2*(x*z + y*t), qd, thr);
            r.m[7] = scaled_entry(2*(y*z - x*t), qd, thr);
            r.m[8] = scaled_entry(t*t - x*x - y*y + z*z, qd, thr);
        end
        return r;
    endfunction

    assign o_pending = expected_mats.size();

    always @(posedge i_clk) begin
        t_rot got;
        t_rot want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            threshold <= THRESH_RESET;
            o_errors <= 0;
            o_matrices <= 0;
            o_zero_seen <= 0;
            expected_mats.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) threshold <= i_cfg.clean_threshold;
            if (i_in.valid && i_in.ready)
                expected_mats.push_back(rotation_of({i_in.q_scalar, i_in.q_x, i_in.q_y,
                                                     i_in.q_z}, threshold));
            if (i_out.valid && i_out.ready) begin
                got.m = {i_out.col2_row2, i_out.col2_row1, i_out.col2_row0,
                         i_out.col1_row2, i_out.col1_row1, i_out.col1_row0,
                         i_out.col0_row2, i_out.col0_row1, i_out.col0_row0};
                got.zero = i_out.zero_quaternion;
                o_matrices <= o_matrices + 1;
                if (got.zero) o_zero_seen <= o_zero_seen + 1;
                if (expected_mats.size() == 0) begin
                    $display("%0t: unexpected matrix transaction %h", $realtime, got);
                    errs++;
                end else begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.m[i] !== want.m[i]) begin
                            $display("%0t: entry %0d expected %0d actual %0d", $realtime, i,
                                     want.m[i], got.m[i]);
                            errs++;
                        end
                    if (got.zero !== want.zero) begin
                        $display("%0t: zero flag expected %b actual %b", $realtime,
                                 want.zero, got.zero);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end
endmodule

>>> bench/tb_quaternion_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_rotation_matrix_unit
// Drives directed and random quaternions under several thresholds with
// random stalls on both sides; the checker compares every matrix.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix_unit;
    import q2rm_pkg::*;
    import q2rm_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 18;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending, matrices, zero_seen;
    int   sent = 0;
    bit   calm = 0;

    q2rm_in_if  in_ch();
    q2rm_out_if out_ch();
    q2rm_cfg_if cfg_ch();

    quaternion_to_rotation_matrix_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    q2rm_tb_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch), .i_cfg(cfg_ch),
        .o_errors(errors), .o_pending(pending), .o_matrices(matrices),
        .o_zero_seen(zero_seen)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.q_scalar = 0; in_ch.q_x = 0; in_ch.q_y = 0; in_ch.q_z = 0;
        cfg_ch.valid = 0;
        cfg_ch.clean_threshold = 0;
        out_ch.ready = 0;
    end

    // receiver stalls in bursts
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 18);
                out_ch.ready <= 0;
                repeat (n) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_quat(t_quat qi);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.q_scalar <= qi.t;
        in_ch.q_x <= qi.x;
        in_ch.q_y <= qi.y;
        in_ch.q_z <= qi.z;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic drain_all();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [TW-1:0] v);
        cfg_ch.valid <= 1;
        cfg_ch.clean_threshold <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_comp rand_comp(int mode);
        case (mode)
            0: return t_comp'($urandom);
            1: return t_comp'(int'($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return t_comp'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    task automatic random_quats(int count);
        t_quat qi;
        int m;
        repeat (count) begin
            m = $urandom_range(0, 9);
            qi.t = rand_comp(m % 4);
            qi.x = rand_comp($urandom_range(0, 3));
            qi.y = rand_comp($urandom_range(0, 3));
            qi.z = rand_comp($urandom_range(0, 3));
            if (m == 9) qi = '0;
            if (m == 8) begin
                qi.x = 0; qi.y = 0;
            end
            send_quat(qi);
        end
    endtask

    initial begin
        t_quat dq[$];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        dq = '{'0, '{16384, 0, 0, 0}, '{-16384, 0, 0, 0}, '{0, 16384, 0, 0},
               '{0, 0, 16384, 0}, '{0, 0, 0, 16384}, '{32767, 32767, 32767, 32767},
               '{-32768, -32768, -32768, -32768}, '{-32768, 32767, -32768, 32767},
               '{1, 0, 0, 0}, '{0, 0, 0, -1}, '{1, 1, 1, 1}, '{11585, 11585, 0, 0},
               '{16384, 1, -1, 2}, '{100, -200, 300, -400}, '{-32768, 0, 0, 1}};
        foreach (dq[i]) send_quat(dq[i]);
        drain_all();

        write_threshold(0);
        foreach (dq[i]) send_quat(dq[i]);
        random_quats(300);
        drain_all();

        write_threshold(TW'(16384));
        random_quats(60);
        drain_all();

        write_threshold(TW'(16385));
        random_quats(40);
        drain_all();

        write_threshold(TW'(32767));
        random_quats(40);
        drain_all();

        write_threshold(TW'($urandom_range(1, 2000)));
        random_quats(400);
        drain_all();

        write_threshold(TW'(16));
        random_quats(300);
        calm = 1;
        random_quats(250);
        drain_all();

        $display("sent %0d quaternions, checked %0d matrices (%0d zero quaternions),",
                 sent, matrices, zero_seen);
        $display("six thresholds from 0 to 32767, with stalls on both channels");
        if (errors == 0)
            $display("tb_quaternion_to_rotation_matrix_unit: clean");
        else
            $display("tb_quaternion_to_rotation_matrix_unit: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_quaternion_to_rotation_matrix_unit: errors");
        $finish;
    end
endmodule
